// ===== hdl/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared types and constants for the RGB median filter core.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int DEF_MAX_RADIUS = 2;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT     = 4096;

  localparam int CH_W   = 8;
  localparam int CH_N   = 3;
  localparam int PIX_W  = CH_N * CH_W;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int RAD_W  = 2;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int IDX_W  = 24;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;
  localparam logic [WID_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } rmf_pix_t;

  typedef struct packed {
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic [COL_W-1:0] col_out;
    logic [ROW_W-1:0] row_out;
    logic             frame_last;
  } rmf_res_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic start;
  } rmf_sel_ctrl_t;

  typedef struct packed {
    logic done;
  } rmf_sel_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_BASE,
    ST_READ,
    ST_FLUSH,
    ST_START,
    ST_SELECT,
    ST_EMIT
  } rmf_state_t;

endpackage

// ===== hdl/rmf_line_store.sv =====
// ----------------------------------------------------------------------------
// rmf_line_store
// Pixel line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rmf_line_store #(
  parameter int DEPTH = 5120,
  parameter int AW    = 13
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rmf_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [rmf_pkg::PIX_W-1:0] rd_data
);
  import rmf_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/rmf_rank_select.sv =====
// ----------------------------------------------------------------------------
// rmf_rank_select
// Collects window pixels and finds the per-channel lower median with a
// bitwise radix select, one bit per cycle from the MSB.
// ----------------------------------------------------------------------------
module rmf_rank_select #(
  parameter int WIN = 25
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  rmf_pkg::rmf_sel_ctrl_t                    ctrl,
  input  logic [rmf_pkg::PIX_W-1:0]                 load_data,
  output rmf_pkg::rmf_sel_stat_t                    stat,
  output logic [rmf_pkg::CH_N-1:0][rmf_pkg::CH_W-1:0] median
);
  import rmf_pkg::*;

  localparam int NW = $clog2(WIN + 1);
  localparam int LW = $clog2(WIN);
  localparam int BW = $clog2(CH_W);

  logic [CH_N-1:0][WIN-1:0][CH_W-1:0] lane;
  logic [CH_N-1:0][WIN-1:0]           mask;
  logic [CH_N-1:0][WIN-1:0]           zero_hit;
  logic [CH_N-1:0][NW-1:0]            rank;
  logic [CH_N-1:0][NW-1:0]            zeros;
  logic [CH_N-1:0]                    take_one;
  logic [NW-1:0]                      cnt;
  logic [BW-1:0]                      bitpos;
  logic                               busy;

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      for (int i = 0; i < WIN; i++) begin
        zero_hit[c][i] = mask[c][i] & ~lane[c][i][bitpos];
      end
      zeros[c]    = NW'($countones(zero_hit[c]));
      take_one[c] = (rank[c] >= zeros[c]);
    end
  end

  assign stat.done = busy && (bitpos == '0);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int c = 0; c < CH_N; c++) begin
        lane[c][cnt[LW-1:0]] <= load_data[PIX_W-1-c*CH_W -: CH_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      busy   <= 1'b0;
      bitpos <= '0;
    end else begin
      if (ctrl.clear) begin
        cnt <= '0;
      end else if (ctrl.load) begin
        cnt <= cnt + 1'b1;
      end
      if (ctrl.start) begin
        busy   <= 1'b1;
        bitpos <= BW'(CH_W - 1);
      end else if (busy) begin
        if (bitpos == '0) begin
          busy <= 1'b0;
        end else begin
          bitpos <= bitpos - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      for (int c = 0; c < CH_N; c++) begin
        rank[c] <= (cnt - 1'b1) >> 1;
        for (int i = 0; i < WIN; i++) begin
          mask[c][i] <= (NW'(i) < cnt);
        end
      end
    end else if (busy) begin
      for (int c = 0; c < CH_N; c++) begin
        median[c][bitpos] <= take_one[c];
        if (take_one[c]) begin
          rank[c] <= rank[c] - zeros[c];
          mask[c] <= mask[c] & ~zero_hit[c];
        end else begin
          mask[c] <= zero_hit[c];
        end
      end
    end
  end

endmodule

// ===== hdl/rgb_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// rgb_median_filter_core
// Streaming per-channel median filter over a clipped square window.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and are kept in a line store of
// (2*MAX_RADIUS+1)*MAX_WIDTH entries. Each pixel or drain item that releases
// an output goes through the accepting idle state, two setup states (clip,
// base), one store read per window pixel (up to (2r+1)^2, one at a time on
// the single read port), a flush state, a start state, the radix select and
// an emit state that waits while the output is stalled; input is stalled
// until the core is idle again, and items that release nothing leave it idle.
// Outputs lag the input by radius rows plus radius pixels; drain items
// (op = 1) flush the rest of the frame. Any register write restarts the frame.
module rgb_median_filter_core #(
  parameter int MAX_RADIUS = rmf_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  rmf_pkg::rmf_pix_t           pix,
  output logic                        res_valid,
  input  logic                        res_stall,
  output rmf_pkg::rmf_res_t           res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmf_pkg::PADDR_W-1:0] paddr,
  input  logic [rmf_pkg::PDATA_W-1:0] pwdata,
  output logic [rmf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import rmf_pkg::*;

  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int WIN   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = WID_W + 1;
  localparam int YW    = HGT_W + 1;

  rmf_state_t state, state_next;

  logic [RAD_W-1:0] radius;
  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;

  logic [RAD_W-1:0] r_eff;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;

  logic [WID_W-1:0] in_col, out_col;
  logic [HGT_W-1:0] in_row, out_row;
  logic [IDX_W-1:0] in_idx, out_idx;
  logic [AW-1:0]    in_addr, out_addr;
  logic             in_done;

  logic [WID_W-1:0] x0, x1, cur_x;
  logic [HGT_W-1:0] y0, y1, cur_y;
  logic [RAD_W-1:0] dx, dy;
  logic [AW-1:0]    row_addr, cur_addr;
  logic             rd_vld;

  logic             cfg_wr, cfg_hit;
  logic             pix_acc, is_pix, emit_now;
  logic [XW-1:0]    col_inc;
  logic [YW-1:0]    row_inc;
  logic             col_wrap, row_wrap;
  logic [IDX_W-1:0] in_idx_inc, rw, pending;
  logic [XW-1:0]    x_hi;
  logic [YW-1:0]    y_hi;
  logic [AW+1:0]    off, base_sum, row_sum;
  logic             rd_last, out_take, frame_last;

  logic [PIX_W-1:0]          rd_data;
  rmf_sel_ctrl_t             sel_ctrl;
  rmf_sel_stat_t             sel_stat;
  logic [CH_N-1:0][CH_W-1:0] median;

  // effective configuration
  always_comb begin
    r_eff = (32'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius;
    if (image_width == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = HGT_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && (paddr[3:2] == REG_RADIUS || paddr[3:2] == REG_WIDTH
                              || paddr[3:2] == REG_HEIGHT);

  always_comb begin
    unique case (paddr[3:2])
      REG_RADIUS: prdata = PDATA_W'(radius);
      REG_WIDTH:  prdata = PDATA_W'(image_width);
      REG_HEIGHT: prdata = PDATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RADIUS_RST;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RADIUS: radius       <= pwdata[RAD_W-1:0];
        REG_WIDTH:  image_width  <= pwdata[WID_W-1:0];
        REG_HEIGHT: image_height <= pwdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // input side
  assign pix_stall = (state != ST_IDLE);
  assign pix_acc   = pix_valid && !pix_stall;
  assign is_pix    = (pix.op == OP_PIXEL) && !in_done;

  always_comb begin
    col_inc    = XW'(in_col) + 1'b1;
    row_inc    = YW'(in_row) + 1'b1;
    col_wrap   = (col_inc >= XW'(w_eff));
    row_wrap   = col_wrap && (row_inc >= YW'(h_eff));
    in_idx_inc = in_idx + 1'b1;
    rw         = (r_eff[0] ? IDX_W'(w_eff) : '0) + (r_eff[1] ? IDX_W'(w_eff) << 1 : '0);
    pending    = out_idx + rw + IDX_W'(r_eff);
    emit_now   = is_pix ? (row_wrap || (in_idx_inc > pending)) : in_done;
  end

  // window setup
  always_comb begin
    x_hi     = XW'(out_col) + XW'(r_eff);
    y_hi     = YW'(out_row) + YW'(r_eff);
    off      = (dy[0] ? (AW+2)'(w_eff) : '0) + (dy[1] ? (AW+2)'(w_eff) << 1 : '0)
               + (AW+2)'(dx);
    base_sum = (AW+2)'(out_addr) + (AW+2)'(DEPTH) - off;
    row_sum  = (AW+2)'(row_addr) + (AW+2)'(w_eff);
    rd_last  = (cur_x == x1) && (cur_y == y1);
  end

  assign out_take   = res_valid && !res_stall;
  assign frame_last = (out_row == h_eff - 1'b1) && (out_col == w_eff - 1'b1);

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (pix_acc && emit_now) state_next = ST_CLIP;
      ST_CLIP:   state_next = ST_BASE;
      ST_BASE:   state_next = ST_READ;
      ST_READ:   if (rd_last) state_next = ST_FLUSH;
      ST_FLUSH:  state_next = ST_START;
      ST_START:  state_next = ST_SELECT;
      ST_SELECT: if (sel_stat.done) state_next = ST_EMIT;
      ST_EMIT:   if (!res_valid || !res_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sel_ctrl.clear = (state == ST_CLIP);
    sel_ctrl.load  = rd_vld;
    sel_ctrl.start = (state == ST_START);
  end

  // window walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_READ);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_CLIP: begin
        if (out_col >= WID_W'(r_eff)) begin
          x0 <= out_col - WID_W'(r_eff);
          dx <= r_eff;
        end else begin
          x0 <= '0;
          dx <= out_col[RAD_W-1:0];
        end
        if (out_row >= HGT_W'(r_eff)) begin
          y0 <= out_row - HGT_W'(r_eff);
          dy <= r_eff;
        end else begin
          y0 <= '0;
          dy <= out_row[RAD_W-1:0];
        end
        x1 <= (x_hi >= XW'(w_eff)) ? w_eff - 1'b1 : x_hi[WID_W-1:0];
        y1 <= (y_hi >= YW'(h_eff)) ? h_eff - 1'b1 : y_hi[HGT_W-1:0];
      end
      ST_BASE: begin
        cur_x <= x0;
        cur_y <= y0;
        if (base_sum >= (AW+2)'(DEPTH)) begin
          row_addr <= AW'(base_sum - (AW+2)'(DEPTH));
          cur_addr <= AW'(base_sum - (AW+2)'(DEPTH));
        end else begin
          row_addr <= AW'(base_sum);
          cur_addr <= AW'(base_sum);
        end
      end
      ST_READ: begin
        if (cur_x == x1) begin
          cur_x <= x0;
          cur_y <= cur_y + 1'b1;
          if (row_sum >= (AW+2)'(DEPTH)) begin
            row_addr <= AW'(row_sum - (AW+2)'(DEPTH));
            cur_addr <= AW'(row_sum - (AW+2)'(DEPTH));
          end else begin
            row_addr <= AW'(row_sum);
            cur_addr <= AW'(row_sum);
          end
        end else begin
          cur_x    <= cur_x + 1'b1;
          cur_addr <= (cur_addr == AW'(DEPTH - 1)) ? '0 : cur_addr + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_hit ||
        (state == ST_EMIT && (!res_valid || !res_stall) && frame_last)) begin
      in_col   <= '0;
      in_row   <= '0;
      in_idx   <= '0;
      in_addr  <= '0;
      in_done  <= 1'b0;
      out_col  <= '0;
      out_row  <= '0;
      out_idx  <= '0;
      out_addr <= '0;
    end else begin
      if (pix_acc && is_pix) begin
        in_idx  <= in_idx_inc;
        in_addr <= (in_addr == AW'(DEPTH - 1)) ? '0 : in_addr + 1'b1;
        if (col_wrap) begin
          in_col <= '0;
          if (row_wrap) begin
            in_row  <= '0;
            in_done <= 1'b1;
          end else begin
            in_row <= row_inc[HGT_W-1:0];
          end
        end else begin
          in_col <= col_inc[WID_W-1:0];
        end
      end
      if (state == ST_EMIT && (!res_valid || !res_stall)) begin
        out_idx  <= out_idx + 1'b1;
        out_addr <= (out_addr == AW'(DEPTH - 1)) ? '0 : out_addr + 1'b1;
        if (out_col == w_eff - 1'b1) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_EMIT && (!res_valid || !res_stall)) begin
      res_valid <= 1'b1;
    end else if (out_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!res_valid || !res_stall)) begin
      res.red_out    <= median[0];
      res.green_out  <= median[1];
      res.blue_out   <= median[2];
      res.col_out    <= out_col[COL_W-1:0];
      res.row_out    <= out_row[ROW_W-1:0];
      res.frame_last <= frame_last;
    end
  end

  rmf_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (pix_acc && is_pix),
    .wr_addr (in_addr),
    .wr_data ({pix.red_in, pix.green_in, pix.blue_in}),
    .rd_en   (state == ST_READ),
    .rd_addr (cur_addr),
    .rd_data (rd_data)
  );

  rmf_rank_select #(
    .WIN (WIN)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sel_ctrl),
    .load_data (rd_data),
    .stat      (sel_stat),
    .median    (median)
  );

endmodule
